// ----- rtl/core/zpg_pkg.sv -----
package zpg_pkg;

  // Width of the result word: value in the low 32 bits, then the running sum
  localparam int unsigned OUT_W  = 96;
  localparam int unsigned COEF_W = 48;
  localparam int unsigned K_W    = 32;

  // 1/pi in unsigned Q0.32
  localparam logic [31:0] IPI_Q32 = 32'd1367130551;
  localparam logic [62:0] SUM_MAX = {63{1'b1}};

  typedef enum logic [1:0] {
    REG_ORDER_N = 2'd0,
    REG_ANGLE_M = 2'd1,
    REG_GRID_W  = 2'd2,
    REG_GRID_H  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } alu_op_t;

  // Rounding right shift applied to a product (SH_0 keeps the raw product)
  typedef enum logic [2:0] {
    SH_0,
    SH_24,
    SH_28,
    SH_30,
    SH_32,
    SH_34
  } rnd_t;

  typedef struct packed {
    logic        start;
    alu_op_t     op;
    rnd_t        rnd;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } alu_rsp_t;

  function automatic logic [63:0] fact(input logic [4:0] i);
    logic [63:0] f;
    unique case (i)
      5'd0:    f = 64'd1;
      5'd1:    f = 64'd1;
      5'd2:    f = 64'd2;
      5'd3:    f = 64'd6;
      5'd4:    f = 64'd24;
      5'd5:    f = 64'd120;
      5'd6:    f = 64'd720;
      5'd7:    f = 64'd5040;
      5'd8:    f = 64'd40320;
      5'd9:    f = 64'd362880;
      5'd10:   f = 64'd3628800;
      5'd11:   f = 64'd39916800;
      5'd12:   f = 64'd479001600;
      5'd13:   f = 64'd6227020800;
      5'd14:   f = 64'd87178291200;
      5'd15:   f = 64'd1307674368000;
      5'd16:   f = 64'd20922789888000;
      5'd17:   f = 64'd355687428096000;
      5'd18:   f = 64'd6402373705728000;
      5'd19:   f = 64'd121645100408832000;
      5'd20:   f = 64'd2432902008176640000;
      default: f = 64'd1;
    endcase
    return f;
  endfunction

endpackage

// ----- rtl/core/zpg_alu.sv -----
module zpg_alu (
  input  logic              clk,
  input  logic              rst,
  input  zpg_pkg::alu_req_t req,
  output zpg_pkg::alu_rsp_t rsp
);
  import zpg_pkg::*;

  typedef enum logic [1:0] {A_IDLE, A_MUL, A_MFIN, A_ITER} astate_t;

  astate_t      state;
  alu_op_t      op;
  rnd_t         rnd;
  logic         neg;
  logic [5:0]   cnt;
  // mul: x,y operand magnitudes; div: x dividend/quotient, y remainder, z divisor;
  // sqrt: x root, y radicand remainder, z trial bit
  logic [63:0]  x, y, z;
  logic [127:0] acc;
  logic         done;
  logic [63:0]  result;

  logic [31:0]  a_half, b_half;
  logic [63:0]  pp;
  logic [127:0] pp_sh, rsum, rsh;
  logic         sat;
  logic [63:0]  mag, mres;
  logic [64:0]  r2;
  logic         dge, sge;
  logic [63:0]  dy_next, dx_next, trial, sx_next;
  logic [63:0]  ua, ub;

  assign rsp.done   = done;
  assign rsp.result = result;

  assign ua = req.a[63] ? 64'(-req.a) : req.a;
  assign ub = req.b[63] ? 64'(-req.b) : req.b;

  // One 32x32 partial product per cycle
  always_comb begin
    a_half = cnt[0] ? x[63:32] : x[31:0];
    b_half = cnt[1] ? y[63:32] : y[31:0];
    pp     = a_half * b_half;
    unique case ({1'b0, cnt[0]} + {1'b0, cnt[1]})
      2'd0:    pp_sh = {64'b0, pp};
      2'd1:    pp_sh = {32'b0, pp, 32'b0};
      default: pp_sh = {pp, 64'b0};
    endcase
  end

  // Round half away from zero, saturate, restore sign
  always_comb begin
    unique case (rnd)
      SH_0:    begin rsum = acc;                      rsh = rsum;       end
      SH_24:   begin rsum = acc + (128'd1 << 23);     rsh = rsum >> 24; end
      SH_28:   begin rsum = acc + (128'd1 << 27);     rsh = rsum >> 28; end
      SH_30:   begin rsum = acc + (128'd1 << 29);     rsh = rsum >> 30; end
      SH_32:   begin rsum = acc + (128'd1 << 31);     rsh = rsum >> 32; end
      default: begin rsum = acc + (128'd1 << 33);     rsh = rsum >> 34; end
    endcase
    sat  = |rsh[127:63];
    mag  = sat ? 64'h7FFF_FFFF_FFFF_FFFF : rsh[63:0];
    mres = neg ? 64'(-mag) : mag;
  end

  // Restoring divide step and square root step
  always_comb begin
    r2      = {y, x[63]};
    dge     = r2 >= {1'b0, z};
    dy_next = dge ? 64'(r2 - {1'b0, z}) : r2[63:0];
    dx_next = {x[62:0], dge};
    trial   = x + z;
    sge     = y >= trial;
    sx_next = sge ? (x >> 1) + z : x >> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        A_IDLE: begin
          if (req.start) begin
            op  <= req.op;
            rnd <= req.rnd;
            cnt <= '0;
            acc <= '0;
            unique case (req.op)
              OP_MUL: begin
                neg   <= req.a[63] ^ req.b[63];
                x     <= ua;
                y     <= ub;
                state <= A_MUL;
              end
              OP_DIV: begin
                x     <= req.a;
                y     <= '0;
                z     <= req.b;
                state <= A_ITER;
              end
              default: begin
                x     <= '0;
                y     <= req.a;
                z     <= 64'd1 << 62;
                state <= A_ITER;
              end
            endcase
          end
        end
        A_MUL: begin
          acc <= acc + pp_sh;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd3) state <= A_MFIN;
        end
        A_MFIN: begin
          result <= mres;
          done   <= 1'b1;
          state  <= A_IDLE;
        end
        A_ITER: begin
          cnt <= cnt + 6'd1;
          if (op == OP_DIV) begin
            x <= dx_next;
            y <= dy_next;
            if (cnt == 6'd63) begin
              result <= dx_next;
              done   <= 1'b1;
              state  <= A_IDLE;
            end
          end else begin
            x <= sx_next;
            if (sge) y <= y - trial;
            z <= z >> 2;
            if (cnt == 6'd31) begin
              result <= sx_next;
              done   <= 1'b1;
              state  <= A_IDLE;
            end
          end
        end
        default: state <= A_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/zernike_polynomial_grid_top.sv -----
// Zernike polynomial over a pixel grid.
// Configuration: write order_n, angle_m, grid_width, grid_height on the cfg
// channel (index 0..3). Each write clears the running sum and, unless the
// configuration is bad, recomputes the radial coefficients and the
// normalization; cfg_ready and s_axis_tready stay low for that.
// Input word: one pixel (col, row). Output word: value (Q4.28), running sum of
// squares (Q31.32), flags inside_res and bad_config on tuser.
// One pixel is worked at a time on a single shared multiply/divide/root unit.
// A pixel off the grid skips the unit; one outside the circle or under a bad
// configuration stops after the three squares; one inside the circle runs the
// three divides, the |m| complex multiplies and the radial Horner loop.
// The next pixel is taken as soon as the previous one is parked in the output
// register; if the receiver stalls, the block holds the finished word and
// parks the next one only once that word is taken. Reset loads n=0, m=0,
// a 2x2 grid, a zero sum and runs the coefficient setup before the first
// word is taken.
module zernike_polynomial_grid_top #(
  parameter int MAX_ORDER = 16,
  parameter int MAX_SIZE  = 1024
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          s_axis_tvalid,
  output logic                                          s_axis_tready,
  // [9:0] col, [19:10] row (at the default grid size)
  input  logic [((2*$clog2(MAX_SIZE)+7)/8)*8-1:0]       s_axis_tdata,
  output logic                                          m_axis_tvalid,
  input  logic                                          m_axis_tready,
  // [31:0] value, [94:32] norm_sum
  output logic [zpg_pkg::OUT_W-1:0]                     m_axis_tdata,
  // [0] inside_res, [1] bad_config
  output logic [1:0]                                    m_axis_tuser,
  input  logic                                          cfg_valid,
  output logic                                          cfg_ready,
  input  logic [1:0]                                    cfg_index,
  input  logic [(($clog2(MAX_SIZE)+1) > 6 ? ($clog2(MAX_SIZE)+1) : 6)-1:0] cfg_data
);
  import zpg_pkg::*;

  localparam int CRD_W = $clog2(MAX_SIZE);
  localparam int DIM_W = CRD_W + 1;
  localparam int SQ_W  = 2 * CRD_W + 1;
  localparam int NCOEF = MAX_ORDER / 2 + 1;
  localparam int CI_W  = NCOEF > 1 ? $clog2(NCOEF) : 1;

  typedef enum logic [4:0] {
    S_IDLE, S_DERIVE, S_CD1, S_CD2, S_CD3, S_ROOT,
    S_SQX, S_SQY, S_SQD, S_DIVS, S_DIVX, S_DIVY,
    S_C1, S_C2, S_C3, S_C4, S_HSET, S_HORN, S_RAD, S_VAL, S_SQV, S_DONE
  } state_t;

  state_t state;

  // Configuration registers
  logic [4:0]        order_n;
  logic signed [5:0] angle_m;
  logic [DIM_W-1:0]  grid_width, grid_height;

  logic [62:0]       square_sum;
  logic signed [COEF_W-1:0] coef [NCOEF];
  logic [K_W-1:0]    knorm;
  logic [CI_W-1:0]   k, hidx;
  logic [5:0]        cidx;
  logic              pend;

  // Pixel working registers
  logic [CRD_W-1:0]  col_r, row_r;
  logic [SQ_W-1:0]   n2, d2;
  logic [32:0]       s;
  logic signed [63:0] ux, uy, re, im, p1, p2, p3, acc, tq;
  logic signed [31:0] vres;
  logic              inside_r;

  // Output register
  logic              out_valid;
  logic [31:0]       out_value;
  logic [62:0]       out_sum;
  logic              out_inside, out_bad;

  alu_req_t req;
  alu_rsp_t rsp;

  zpg_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Derived configuration
  logic [5:0]       m_abs, n6, j6, hsum;
  logic             bad;
  logic [CI_W-1:0]  jt;
  logic [DIM_W-1:0] wc, hc, dmax;
  logic [36:0]      kprod;
  logic [63:0]      root_arg;

  always_comb begin
    m_abs = angle_m[5] ? 6'(-angle_m) : 6'(angle_m);
    n6    = {1'b0, order_n};
    bad   = (int'(order_n) > MAX_ORDER) || (m_abs > n6) || (n6[0] ^ m_abs[0]);
    j6    = (n6 - m_abs) >> 1;
    hsum  = (n6 + m_abs) >> 1;
    jt    = j6[CI_W-1:0];
    kprod = 37'(n6 + 6'd1) * 37'(IPI_Q32);
    root_arg = (angle_m == 6'sd0) ? (64'(kprod) << 23) : (64'(kprod) << 24);
  end

  // Clamp the grid and place the pixel around the centre (doubled units)
  logic signed [DIM_W+1:0] dx, dy;
  logic signed [63:0]      dx64, dy64, dmax64, adx, ady, v64;

  always_comb begin
    if (grid_width < DIM_W'(2))             wc = DIM_W'(2);
    else if (grid_width > DIM_W'(MAX_SIZE)) wc = DIM_W'(MAX_SIZE);
    else                                    wc = grid_width;
    if (grid_height < DIM_W'(2))             hc = DIM_W'(2);
    else if (grid_height > DIM_W'(MAX_SIZE)) hc = DIM_W'(MAX_SIZE);
    else                                     hc = grid_height;
    dmax   = (wc > hc ? wc : hc) - DIM_W'(1);
    dx     = signed'({2'b0, col_r, 1'b0}) - signed'({2'b0, wc - DIM_W'(1)});
    dy     = signed'({2'b0, row_r, 1'b0}) - signed'({2'b0, hc - DIM_W'(1)});
    dx64   = 64'(dx);
    dy64   = 64'(dy);
    dmax64 = signed'(64'(dmax));
    adx    = dx[DIM_W+1] ? -dx64 : dx64;
    ady    = dy[DIM_W+1] ? -dy64 : dy64;
    v64    = 64'(vres);
  end

  logic [CRD_W-1:0] col_in, row_in;
  logic             on_grid;
  assign col_in  = s_axis_tdata[CRD_W-1:0];
  assign row_in  = s_axis_tdata[2*CRD_W-1:CRD_W];
  assign on_grid = ({1'b0, col_in} < wc) && ({1'b0, row_in} < hc);

  assign cfg_ready     = (state == S_IDLE);
  assign s_axis_tready = (state == S_IDLE) && !cfg_valid;

  // Drive the shared unit from the current state
  logic use_alu;
  always_comb begin
    use_alu = 1'b1;
    req.op  = OP_MUL;
    req.rnd = SH_0;
    req.a   = '0;
    req.b   = '0;
    unique case (state)
      S_CD1: begin
        req.op = OP_DIV;
        req.a  = fact(5'(n6 - 6'(k)));
        req.b  = fact(5'(k));
      end
      S_CD2: begin
        req.op = OP_DIV;
        req.a  = tq;
        req.b  = fact(5'(hsum - 6'(k)));
      end
      S_CD3: begin
        req.op = OP_DIV;
        req.a  = tq;
        req.b  = fact(5'(j6 - 6'(k)));
      end
      S_ROOT: begin
        req.op = OP_SQRT;
        req.a  = root_arg;
      end
      S_SQX: begin req.a = dx64;   req.b = dx64;   end
      S_SQY: begin req.a = dy64;   req.b = dy64;   end
      S_SQD: begin req.a = dmax64; req.b = dmax64; end
      S_DIVS: begin
        req.op = OP_DIV;
        req.a  = 64'({n2, 32'b0}) + 64'(d2 >> 1);
        req.b  = 64'(d2);
      end
      S_DIVX: begin
        req.op = OP_DIV;
        req.a  = {adx[33:0], 30'b0} + 64'(dmax >> 1);
        req.b  = dmax64;
      end
      S_DIVY: begin
        req.op = OP_DIV;
        req.a  = {ady[33:0], 30'b0} + 64'(dmax >> 1);
        req.b  = dmax64;
      end
      S_C1: begin req.rnd = SH_30; req.a = re; req.b = ux; end
      S_C2: begin req.rnd = SH_30; req.a = im; req.b = uy; end
      S_C3: begin req.rnd = SH_30; req.a = re; req.b = uy; end
      S_C4: begin req.rnd = SH_30; req.a = im; req.b = ux; end
      S_HORN: begin req.rnd = SH_32; req.a = acc; req.b = 64'(s); end
      S_RAD: begin
        req.rnd = SH_34;
        req.a   = acc;
        req.b   = angle_m[5] ? im : re;
      end
      S_VAL: begin req.rnd = SH_28; req.a = acc; req.b = 64'(knorm); end
      S_SQV: begin req.rnd = SH_24; req.a = v64; req.b = v64; end
      default: use_alu = 1'b0;
    endcase
    req.start = use_alu && !pend;
  end

  logic signed [63:0] res, hnext;
  logic [63:0]        sum_add;
  assign res     = signed'(rsp.result);
  assign hnext   = res + signed'({coef[hidx][31:0], 32'b0});
  assign sum_add = {1'b0, square_sum} + rsp.result;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_DERIVE;
      order_n     <= '0;
      angle_m     <= '0;
      grid_width  <= DIM_W'(2);
      grid_height <= DIM_W'(2);
      square_sum  <= '0;
      pend        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // track the outstanding unit request
      if (rsp.done)       pend <= 1'b0;
      else if (req.start) pend <= 1'b1;

      if (out_valid && m_axis_tready && (state != S_DONE)) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
              REG_ORDER_N: order_n     <= cfg_data[4:0];
              REG_ANGLE_M: angle_m     <= signed'(cfg_data[5:0]);
              REG_GRID_W:  grid_width  <= cfg_data[DIM_W-1:0];
              REG_GRID_H:  grid_height <= cfg_data[DIM_W-1:0];
              default:     order_n     <= order_n;
            endcase
            square_sum <= '0;
            state      <= S_DERIVE;
          end else if (s_axis_tvalid) begin
            col_r <= col_in;
            row_r <= row_in;
            if (on_grid) begin
              state <= S_SQX;
            end else begin
              vres     <= '0;
              inside_r <= 1'b0;
              state    <= S_DONE;
            end
          end
        end
        // coefficient setup
        S_DERIVE: begin
          k     <= '0;
          state <= bad ? S_IDLE : S_CD1;
        end
        S_CD1: if (rsp.done) begin tq <= res; state <= S_CD2; end
        S_CD2: if (rsp.done) begin tq <= res; state <= S_CD3; end
        S_CD3: if (rsp.done) begin
          coef[k] <= k[0] ? -COEF_W'(res) : COEF_W'(res);
          if (k == jt) begin
            state <= S_ROOT;
          end else begin
            k     <= k + CI_W'(1);
            state <= S_CD1;
          end
        end
        S_ROOT: if (rsp.done) begin
          knorm <= rsp.result[K_W-1:0];
          state <= S_IDLE;
        end
        // geometry
        S_SQX: if (rsp.done) begin n2 <= SQ_W'(rsp.result); state <= S_SQY; end
        S_SQY: if (rsp.done) begin n2 <= n2 + SQ_W'(rsp.result); state <= S_SQD; end
        S_SQD: if (rsp.done) begin
          d2       <= SQ_W'(rsp.result);
          inside_r <= (64'(n2) <= rsp.result);
          if ((64'(n2) > rsp.result) || bad) begin
            vres  <= '0;
            state <= S_DONE;
          end else begin
            state <= S_DIVS;
          end
        end
        S_DIVS: if (rsp.done) begin s <= rsp.result[32:0]; state <= S_DIVX; end
        S_DIVX: if (rsp.done) begin
          ux    <= dx[DIM_W+1] ? -res : res;
          state <= S_DIVY;
        end
        S_DIVY: if (rsp.done) begin
          uy    <= dy[DIM_W+1] ? -res : res;
          re    <= 64'sd1 <<< 30;
          im    <= '0;
          cidx  <= '0;
          state <= (m_abs == 6'd0) ? S_HSET : S_C1;
        end
        // angular term: u^|m| by repeated complex multiply
        S_C1: if (rsp.done) begin p1 <= res; state <= S_C2; end
        S_C2: if (rsp.done) begin p2 <= res; state <= S_C3; end
        S_C3: if (rsp.done) begin p3 <= res; state <= S_C4; end
        S_C4: if (rsp.done) begin
          re   <= p1 - p2;
          im   <= p3 + res;
          cidx <= cidx + 6'd1;
          state <= (cidx + 6'd1 == m_abs) ? S_HSET : S_C1;
        end
        // radial term by Horner in s
        S_HSET: begin
          acc   <= signed'({coef[0][31:0], 32'b0});
          hidx  <= CI_W'(1);
          state <= (jt == '0) ? S_RAD : S_HORN;
        end
        S_HORN: if (rsp.done) begin
          acc <= hnext;
          if (hidx == jt) state <= S_RAD;
          else            hidx  <= hidx + CI_W'(1);
        end
        S_RAD: if (rsp.done) begin acc <= res; state <= S_VAL; end
        S_VAL: if (rsp.done) begin
          if (res[63:31] != {33{res[63]}}) vres <= res[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          else                             vres <= res[31:0];
          state <= S_SQV;
        end
        S_SQV: if (rsp.done) begin
          square_sum <= sum_add[63] ? SUM_MAX : sum_add[62:0];
          state      <= S_DONE;
        end
        // park the result once the output register is free
        S_DONE: begin
          if (!out_valid || m_axis_tready) begin
            out_valid  <= 1'b1;
            out_value  <= vres;
            out_inside <= inside_r;
            out_sum    <= square_sum;
            out_bad    <= bad;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_sum, out_value};
  assign m_axis_tuser  = {out_bad, out_inside};

endmodule

// ----- rtl/core/zpg_checker.sv -----
module zpg_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // Stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // A taken pixel keeps both channels closed on the next cycle
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !cfg_ready)
    else $error("block ready right after taking a pixel");

  // A register write starts the coefficient setup
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !cfg_ready && !s_axis_tready)
    else $error("block ready right after a register write");

  // Bad configuration gives a zero value
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[31:0] == 32'd0)
    else $error("nonzero value under bad configuration");

  // Pixel outside the circle gives a zero value
  a_out_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[31:0] == 32'd0)
    else $error("nonzero value outside the circle");

endmodule

bind zernike_polynomial_grid_top zpg_checker u_zpg_checker (.*);
